@@ hw/rtl/agd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accept-Encoding gzip detector package
// Shared character codes and the request type that carries one header
// byte from the input register to the parser.
// ----------------------------------------------------------------------------
package agd_pkg;

  // Characters that the parser looks for.
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChSemi  = 8'h3B;  // ';'
  localparam logic [7:0] ChStar  = 8'h2A;  // '*'
  localparam logic [7:0] ChDash  = 8'h2D;  // '-'
  localparam logic [7:0] ChDot   = 8'h2E;  // '.'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNul   = 8'h00;

  // Length of the word "gzip".
  localparam logic [2:0] GzipLen = 3'd4;

  // One header byte handed to the parser in the cycle it is consumed.
  typedef struct packed {
    logic       fire;
    logic [7:0] ch;
    logic       last;
  } agd_req_t;

  // Lower-case letters of "gzip", by position.
  function automatic logic [7:0] gzip_char(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h67;  // 'g'
      2'd1: r = 8'h7A;  // 'z'
      2'd2: r = 8'h69;  // 'i'
      2'd3: r = 8'h70;  // 'p'
      default: r = 8'h67;
    endcase
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_tok(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == ChStar) || (c == ChDash);
  endfunction

  function automatic logic is_qch(input logic [7:0] c);
    return is_digit(c) || (c == ChDot) || (c == ChDash);
  endfunction

endpackage

@@ hw/rtl/agd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accept-Encoding parser
// Per-byte state machine that walks the encoding list, matches "gzip" and
// reduces each q-value to a positive flag. Gives the decision on the last
// byte of a header value and then returns to its reset state.
// ----------------------------------------------------------------------------
module agd_parser
  import agd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  agd_req_t req_i,
  output logic     gzip_ok_o
);

  typedef enum logic [2:0] {
    PH_LIST  = 3'd0,
    PH_LEAD  = 3'd1,
    PH_TOKEN = 3'd2,
    PH_AFTER = 3'd3,
    PH_SEMI  = 3'd4,
    PH_EQ    = 3'd5,
    PH_QWS   = 3'd6,
    PH_QVAL  = 3'd7
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [2:0] count_q, count_d;
  logic       mismatch_q, mismatch_d;
  logic       neg_q, neg_d;
  logic       dot_q, dot_d;
  logic       nz_q, nz_d;
  logic       closed_q, closed_d;
  logic       made_q, made_d;
  logic       gzip_q, gzip_d;

  logic       do_after, do_list, do_lead;
  logic [7:0] c;
  logic [7:0] low;
  logic       tok_gzip;
  logic       q_pos;
  logic       end_gzip;

  // Answer for a header that ends in the given phase.
  function automatic logic end_dec(input phase_e ph, input logic [2:0] cnt,
                                   input logic mis, input logic neg,
                                   input logic nz);
    logic g;
    g = !mis && (cnt == GzipLen);
    unique case (ph)
      PH_TOKEN, PH_AFTER: return g;
      PH_QVAL:            return g && !neg && nz;
      default:            return 1'b0;
    endcase
  endfunction

  assign c        = req_i.ch;
  assign low      = is_alpha(c) ? (c | 8'h20) : c;
  assign tok_gzip = !mismatch_q && (count_q == GzipLen);
  assign q_pos    = !neg_q && nz_q;

  // Next-state logic: one byte may fall through several list phases.
  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    mismatch_d = mismatch_q;
    neg_d      = neg_q;
    dot_d      = dot_q;
    nz_d       = nz_q;
    closed_d   = closed_q;
    made_d     = made_q;
    gzip_d     = gzip_q;
    do_after   = 1'b0;
    do_list    = 1'b0;
    do_lead    = 1'b0;
    end_gzip   = 1'b0;

    if (req_i.fire && !made_q) begin
      if (c == ChNul) begin
        made_d = 1'b1;
        gzip_d = end_dec(phase_q, count_q, mismatch_q, neg_q, nz_q);
      end else begin
        unique case (phase_q)
          PH_LIST: do_list = 1'b1;
          PH_LEAD: do_lead = 1'b1;
          PH_TOKEN: begin
            if (is_tok(c)) begin
              if ((count_q < GzipLen) && (low == gzip_char(count_q[1:0]))) begin
                count_d = count_q + 3'd1;
              end else begin
                mismatch_d = 1'b1;
              end
            end else begin
              do_after = 1'b1;
            end
          end
          PH_AFTER: do_after = 1'b1;
          PH_SEMI: begin
            if (!is_blank(c)) phase_d = PH_EQ;
          end
          PH_EQ: begin
            if (!is_blank(c)) phase_d = PH_QWS;
          end
          PH_QWS: begin
            if (!is_blank(c)) begin
              neg_d    = (c == ChDash);
              dot_d    = (c == ChDot);
              nz_d     = is_digit(c) && (c != ChZero);
              closed_d = 1'b0;
              if (is_qch(c)) begin
                phase_d = PH_QVAL;
              end else begin
                do_list = 1'b1;
              end
            end
          end
          PH_QVAL: begin
            if (is_qch(c)) begin
              if (!closed_q) begin
                if (c == ChDash) begin
                  closed_d = 1'b1;
                end else if (c == ChDot) begin
                  if (dot_q) closed_d = 1'b1;
                  else       dot_d    = 1'b1;
                end else if (c != ChZero) begin
                  nz_d = 1'b1;
                end
              end
            end else if (q_pos && tok_gzip) begin
              made_d = 1'b1;
              gzip_d = 1'b1;
            end else begin
              do_list = 1'b1;
            end
          end
          default: do_list = 1'b1;
        endcase

        // After a token: blanks, a parameter, or the end of the element.
        if (do_after) begin
          if (is_blank(c)) begin
            phase_d = PH_AFTER;
          end else if (c == ChSemi) begin
            phase_d = PH_SEMI;
          end else if (tok_gzip) begin
            phase_d = PH_AFTER;
            made_d  = 1'b1;
            gzip_d  = 1'b1;
          end else begin
            do_list = 1'b1;
          end
        end

        // List start: one optional comma.
        if (do_list) begin
          if (c == ChComma) phase_d = PH_LEAD;
          else              do_lead = 1'b1;
        end

        // Leading blanks, then the first character of a token.
        if (do_lead) begin
          if (is_blank(c)) begin
            phase_d = PH_LEAD;
          end else if (is_tok(c)) begin
            phase_d    = PH_TOKEN;
            count_d    = (low == gzip_char(2'd0)) ? 3'd1 : 3'd0;
            mismatch_d = (low != gzip_char(2'd0));
          end else begin
            phase_d = PH_LEAD;
            made_d  = 1'b1;
            gzip_d  = 1'b0;
          end
        end
      end
    end

    // Decision for the last byte.
    end_gzip = made_d ? gzip_d : end_dec(phase_d, count_d, mismatch_d, neg_d, nz_d);
  end

  assign gzip_ok_o = end_gzip;

  // State registers; the last byte returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LIST;
      count_q    <= 3'd0;
      mismatch_q <= 1'b0;
      neg_q      <= 1'b0;
      dot_q      <= 1'b0;
      nz_q       <= 1'b0;
      closed_q   <= 1'b0;
      made_q     <= 1'b0;
      gzip_q     <= 1'b0;
    end else if (req_i.fire && req_i.last) begin
      phase_q    <= PH_LIST;
      count_q    <= 3'd0;
      mismatch_q <= 1'b0;
      neg_q      <= 1'b0;
      dot_q      <= 1'b0;
      nz_q       <= 1'b0;
      closed_q   <= 1'b0;
      made_q     <= 1'b0;
      gzip_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      mismatch_q <= mismatch_d;
      neg_q      <= neg_d;
      dot_q      <= dot_d;
      nz_q       <= nz_d;
      closed_q   <= closed_d;
      made_q     <= made_d;
      gzip_q     <= gzip_d;
    end
  end

endmodule

@@ hw/rtl/accept_encoding_gzip_detector.sv @@
`timescale 1ns / 1ps
// The last byte waits in the input register; its result is registered in the result register when it moves on.
// Throughput: one header byte per cycle, except while a last byte waits for a stalled output.
// Other bytes keep flowing while a finished result waits at the output; a last
// byte waits in the input register until that result is taken.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to the start of a list.
// ----------------------------------------------------------------------------
// Accept-Encoding gzip detector
// Input register, per-byte parser and result register; one decision per
// header value, given with its last byte.
// ----------------------------------------------------------------------------
module accept_encoding_gzip_detector
  import agd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] header_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       gzip_ok_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       final_q;
  logic       out_valid_q;
  logic       gzip_ok_q;
  logic       out_blocked;
  logic       advance;
  logic       in_accept;
  logic       res_gzip;
  agd_req_t   req;

  // The byte in the input register moves on unless it needs the busy output.
  assign out_blocked = out_valid_q && out_stall_i;
  assign advance     = in_valid_q && !(final_q && out_blocked);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q  <= header_byte_i;
      final_q <= final_byte_i;
    end
  end

  assign req = '{fire: advance, ch: byte_q, last: final_q};

  agd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .gzip_ok_o (res_gzip)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && final_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && final_q) begin
      gzip_ok_q <= res_gzip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gzip_ok_o   = gzip_ok_q;

endmodule
